// File: rtl/core/dfps_pkg.sv
// Types and constants for the dipole field position solver pipeline.
`timescale 1ns / 1ps
`default_nettype none

package dfps_pkg;

   // Field formats
   localparam int MEAS_W   = 24;
   localparam int GAIN_W   = 32;
   localparam int POS_W    = 32;
   localparam int N_ELEM   = 9;
   localparam int N_AXIS   = 3;

   // Datapath widths
   localparam int X_W      = 88;   // normalized element, Q.32
   localparam int Y_W      = 29;   // element after exponent alignment
   localparam int SQ_W     = 58;
   localparam int COL_W    = 60;
   localparam int S_W      = 62;
   localparam int U_W      = 63;
   localparam int D9_W     = 66;
   localparam int W_W      = 59;
   localparam int T_W      = 62;
   localparam int H_W      = 21;
   localparam int PROD_W   = 53;

   // Pipeline section lengths (one quotient or root bit per stage in the dividers and square roots)
   localparam int X_STEPS     = 88;
   localparam int R_STEPS     = 33;
   localparam int Q_STEPS     = 32;
   localparam int W_STEPS     = 60;
   localparam int T_STEPS     = 62;
   localparam int CUBE_STAGES = 2 * H_W;

   // Register indexes
   localparam logic [2:0] CSR_FLIP_MASK = 3'd0;
   localparam logic [2:0] CSR_TX_GAIN0  = 3'd1;
   localparam logic [2:0] CSR_TX_GAIN1  = 3'd2;
   localparam logic [2:0] CSR_TX_GAIN2  = 3'd3;
   localparam logic [2:0] CSR_RX_GAIN0  = 3'd4;
   localparam logic [2:0] CSR_RX_GAIN1  = 3'd5;
   localparam logic [2:0] CSR_RX_GAIN2  = 3'd6;

   localparam logic [GAIN_W-1:0] GAIN_RESET = 32'd65536;

   // Status codes
   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_ZERO = 2'd1;
   localparam logic [1:0] STATUS_NEG  = 2'd2;

   // Side data carried through the radicand divider and its square root
   typedef struct packed {
      logic [D9_W-1:0] w0;    // normalized start remainder for the h^6 divider
      logic [D9_W-1:0] d9;    // 9*S
      logic [2:0]      sw;    // final right shift of the h^6 quotient
      logic [5:0]      sh;    // output shift 34-n
      logic [2:0]      neg;
      logic            zero;
   } wside_type;

   // Side data carried through the h^6 divider and the root stages
   typedef struct packed {
      logic [2:0][31:0] q;
      logic [5:0]       sh;
      logic [2:0]       neg;
      logic             zero;
   } tail_type;

endpackage

`default_nettype wire

// File: rtl/core/dipole_field_position_solver.sv
// Dipole field position solver: fully pipelined top level.
//
//  channel  ports                                   handshake
//  -------  --------------------------------------  ------------------------------
//  input    req_m00 .. req_m22                      start & !busy
//  result   rsp_pos_a/b/c, rsp_status               rsp_valid, one cycle per result
//  config   csr_index, csr_wdata                    csr_write_en
//
// One transaction is accepted per cycle; busy stays low. The pipeline runs through the
// bit-per-stage dividers (88-bit element normalize, 33-bit radicand, 60-bit h^6) and the
// square and cube root stages. Synchronous reset clears the valid chain and sets every
// gain to 1.0. There is no stall: results appear on rsp_valid for a single cycle each.
`timescale 1ns / 1ps
`default_nettype none

module dipole_field_position_solver (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic signed [23:0] req_m00,
   input  logic signed [23:0] req_m01,
   input  logic signed [23:0] req_m02,
   input  logic signed [23:0] req_m10,
   input  logic signed [23:0] req_m11,
   input  logic signed [23:0] req_m12,
   input  logic signed [23:0] req_m20,
   input  logic signed [23:0] req_m21,
   input  logic signed [23:0] req_m22,
   output logic        rsp_valid,
   output logic [31:0] rsp_pos_a,
   output logic [31:0] rsp_pos_b,
   output logic [31:0] rsp_pos_c,
   output logic [1:0]  rsp_status,
   input  logic        csr_write_en,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int XS  = dfps_pkg::X_STEPS;
   localparam int RS  = dfps_pkg::R_STEPS;
   localparam int QS  = dfps_pkg::Q_STEPS;
   localparam int WS  = dfps_pkg::W_STEPS;
   localparam int TS  = dfps_pkg::T_STEPS;
   localparam int CS  = dfps_pkg::CUBE_STAGES;
   localparam int LAT = XS + RS + QS + WS + TS + CS + 15;

   function automatic logic [6:0] bit_len(input logic [87:0] v);
      logic [6:0] n;
      n = '0;
      for (int i = 0; i < 88; i++) begin
         if (v[i]) n = 7'(i + 1);
      end
      return n;
   endfunction

   // ---------------- configuration ----------------
   logic [31:0] tx_gain_ff [3];
   logic [31:0] rx_gain_ff [3];

   // the flip mask only changes signs, which the squares discard, so it is not stored
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            tx_gain_ff[i] <= dfps_pkg::GAIN_RESET;
            rx_gain_ff[i] <= dfps_pkg::GAIN_RESET;
         end
      end else if (csr_write_en) begin
         case (csr_index)
            dfps_pkg::CSR_FLIP_MASK: ;
            dfps_pkg::CSR_TX_GAIN0: tx_gain_ff[0] <= csr_wdata;
            dfps_pkg::CSR_TX_GAIN1: tx_gain_ff[1] <= csr_wdata;
            dfps_pkg::CSR_TX_GAIN2: tx_gain_ff[2] <= csr_wdata;
            dfps_pkg::CSR_RX_GAIN0: rx_gain_ff[0] <= csr_wdata;
            dfps_pkg::CSR_RX_GAIN1: rx_gain_ff[1] <= csr_wdata;
            dfps_pkg::CSR_RX_GAIN2: rx_gain_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   logic [23:0] meas [9];
   assign meas[0] = req_m00;
   assign meas[1] = req_m01;
   assign meas[2] = req_m02;
   assign meas[3] = req_m10;
   assign meas[4] = req_m11;
   assign meas[5] = req_m12;
   assign meas[6] = req_m20;
   assign meas[7] = req_m21;
   assign meas[8] = req_m22;

   // ---------------- pipeline registers ----------------
   logic [LAT-1:0] vld_ff;

   // element divider: mag*2^64 / (tx*rx)
   logic [87:0] xr_ff [0:XS][0:8];
   logic [87:0] xr_in [0:XS][0:8];
   logic [87:0] xq_ff [0:XS][0:8];
   logic [87:0] xq_in [0:XS][0:8];
   logic [63:0] xd_ff [0:XS][0:8];
   logic [63:0] xd_in [0:XS][0:8];

   // energy stages
   logic [87:0] x1_ff [9];
   logic [87:0] x1_in [9];
   logic [5:0]  e1_ff, e1_in, e2_ff, e2_in, e3_ff, e3_in, e4_ff, e4_in, e5_ff, e5_in;
   logic [5:0]  e6_ff, e6_in;
   logic [28:0] y2_ff [9];
   logic [28:0] y2_in [9];
   logic [57:0] sq3_ff [9];
   logic [57:0] sq3_in [9];
   logic [59:0] col4_ff [3];
   logic [59:0] col4_in [3];
   logic [59:0] col5_ff [3];
   logic [59:0] col5_in [3];
   logic [61:0] s5_ff, s5_in, s6_ff, s6_in, s7_ff, s7_in;
   logic [5:0]  l6_ff, l6_in, l7_ff, l7_in;
   logic [65:0] d96_ff, d96_in, d97_ff, d97_in;
   logic [62:0] u6_ff [3];
   logic [62:0] u6_in [3];
   logic [62:0] u7_ff [3];
   logic [62:0] u7_in [3];
   logic [2:0]  neg6_ff, neg6_in, neg7_ff, neg7_in;
   logic        zero6_ff, zero6_in, zero7_ff, zero7_in;
   logic [6:0]  l97_ff, l97_in;
   logic [7:0]  a7_ff, a7_in;
   logic [4:0]  q67_ff, q67_in;

   // radicand divider: u*2^30 / S
   logic [64:0] rr_ff [0:RS][0:2];
   logic [64:0] rr_in [0:RS][0:2];
   logic [32:0] rq_ff [0:RS][0:2];
   logic [32:0] rq_in [0:RS][0:2];
   logic [61:0] rs_ff [0:RS];
   logic [61:0] rs_in [0:RS];
   dfps_pkg::wside_type rside_ff [0:RS];
   dfps_pkg::wside_type rside_in [0:RS];

   // radicand square root
   logic [63:0] qv_ff [0:QS][0:2];
   logic [63:0] qv_in [0:QS][0:2];
   logic [33:0] qrem_ff [0:QS][0:2];
   logic [33:0] qrem_in [0:QS][0:2];
   logic [31:0] qroot_ff [0:QS][0:2];
   logic [31:0] qroot_in [0:QS][0:2];
   dfps_pkg::wside_type qside_ff [0:QS];
   dfps_pkg::wside_type qside_in [0:QS];

   // h^6 divider: 2^p / (9*S), normalized
   logic [65:0] wr_ff [0:WS];
   logic [65:0] wr_in [0:WS];
   logic [65:0] wd_ff [0:WS];
   logic [65:0] wd_in [0:WS];
   logic [59:0] wq_ff [0:WS];
   logic [59:0] wq_in [0:WS];
   logic [2:0]  wsw_ff [0:WS];
   logic [2:0]  wsw_in [0:WS];
   dfps_pkg::tail_type wtail_ff [0:WS];
   dfps_pkg::tail_type wtail_in [0:WS];

   // square root of W*2^64
   logic [123:0] tv_ff [0:TS];
   logic [123:0] tv_in [0:TS];
   logic [63:0]  trem_ff [0:TS];
   logic [63:0]  trem_in [0:TS];
   logic [61:0]  troot_ff [0:TS];
   logic [61:0]  troot_in [0:TS];
   dfps_pkg::tail_type ttail_ff [0:TS];
   dfps_pkg::tail_type ttail_in [0:TS];

   // cube root, two stages per bit
   logic [61:0] ct_ff [0:CS];
   logic [61:0] ct_in [0:CS];
   logic [20:0] ch_ff [0:CS];
   logic [20:0] ch_in [0:CS];
   logic [20:0] cc_ff [0:CS];
   logic [20:0] cc_in [0:CS];
   logic [41:0] c2_ff [0:CS];
   logic [41:0] c2_in [0:CS];
   dfps_pkg::tail_type ctail_ff [0:CS];
   dfps_pkg::tail_type ctail_in [0:CS];

   // output product and result registers
   logic [52:0] prod_ff [3];
   logic [52:0] prod_in [3];
   dfps_pkg::tail_type ftail_ff, ftail_in;
   logic [31:0] pos_ff [3];
   logic [31:0] pos_in [3];
   logic [1:0]  status_ff, status_in;

   always_comb begin
      logic [23:0]  mag;
      logic [31:0]  tg, rg;
      logic [63:0]  gprod;
      logic [88:0]  xr2, xdd;
      logic         xbit;
      logic [87:0]  orv;
      logic [6:0]   bl;
      logic [62:0]  six;
      logic [8:0]   a_w;
      logic [15:0]  mul6;
      logic [7:0]   r6w, sww;
      logic [65:0]  rr2, rdd;
      logic [35:0]  qremx, qtrial;
      logic [66:0]  wr2, wdd;
      logic [58:0]  wv;
      logic [65:0]  tremx, ttrial;
      logic [20:0]  ccand;
      logic [62:0]  c3;
      logic [52:0]  shifted;

      // element magnitudes and gain products
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            mag   = meas[3*i+j][23] ? (~meas[3*i+j] + 24'd1) : meas[3*i+j];
            tg    = (tx_gain_ff[i] == 32'd0) ? 32'd1 : tx_gain_ff[i];
            rg    = (rx_gain_ff[j] == 32'd0) ? 32'd1 : rx_gain_ff[j];
            gprod = tg * rg;
            xr_in[0][3*i+j] = 88'(mag);
            xq_in[0][3*i+j] = '0;
            xd_in[0][3*i+j] = gprod;
         end
      end

      // divisor is gain product << 24 so that the start remainder sits below it
      for (int k = 0; k < XS; k++) begin
         for (int l = 0; l < 9; l++) begin
            xr2 = {xr_ff[k][l], 1'b0};
            xdd = {1'b0, xd_ff[k][l], 24'b0};
            if (xr2 >= xdd) begin
               xr_in[k+1][l] = 88'(xr2 - xdd);
               xbit = 1'b1;
            end else begin
               xr_in[k+1][l] = xr2[87:0];
               xbit = 1'b0;
            end
            xq_in[k+1][l] = {xq_ff[k][l][86:0], xbit};
            xd_in[k+1][l] = xd_ff[k][l];
         end
      end

      // common exponent: bit length of the largest element equals that of the OR
      orv = '0;
      for (int l = 0; l < 9; l++) begin
         orv = orv | xq_ff[XS][l];
         x1_in[l] = xq_ff[XS][l];
      end
      bl    = bit_len(orv);
      e1_in = (bl > 7'd29) ? 6'(bl - 7'd29) : 6'd0;

      for (int l = 0; l < 9; l++) begin
         y2_in[l]  = 29'(x1_ff[l] >> e1_ff);
         sq3_in[l] = y2_ff[l] * y2_ff[l];
      end
      e2_in = e1_ff;
      e3_in = e2_ff;

      for (int c = 0; c < 3; c++) begin
         col4_in[c] = 60'(sq3_ff[c]) + 60'(sq3_ff[3+c]) + 60'(sq3_ff[6+c]);
         col5_in[c] = col4_ff[c];
      end
      e4_in = e3_ff;
      s5_in = 62'(col4_ff[0]) + 62'(col4_ff[1]) + 62'(col4_ff[2]);
      e5_in = e4_ff;

      l6_in   = 6'(bit_len(88'(s5_ff)));
      d96_in  = 66'({s5_ff, 3'b000}) + 66'(s5_ff);
      for (int c = 0; c < 3; c++) begin
         six        = 63'({col5_ff[c], 2'b00}) + 63'({col5_ff[c], 1'b0});
         neg6_in[c] = (six < 63'(s5_ff));
         u6_in[c]   = six - 63'(s5_ff);
      end
      zero6_in = (s5_ff == '0);
      s6_in    = s5_ff;
      e6_in    = e5_ff;

      // a = E - L + 120 with E = 65 - 2e; a/6 by reciprocal
      l97_in = bit_len(88'(d96_ff));
      a_w    = 9'd185 - 9'({e6_ff, 1'b0}) - 9'(l6_ff);
      a7_in  = a_w[7:0];
      mul6   = a_w[7:0] * 8'd171;
      q67_in = mul6[14:10];
      l7_in  = l6_ff;
      d97_in = d96_ff;
      for (int c = 0; c < 3; c++) u7_in[c] = u6_ff[c];
      neg7_in  = neg6_ff;
      zero7_in = zero6_ff;
      s7_in    = s6_ff;

      // radicand divider entry, plus shift setup for the h^6 divider
      r6w = a7_ff - (8'({q67_ff, 2'b00}) + 8'({q67_ff, 1'b0}));
      sww = 8'(l97_ff) + 8'd3 - 8'(l7_ff) - 8'(r6w[2:0]);
      rside_in[0].w0   = 66'd1 << (l97_ff - 7'd1);
      rside_in[0].d9   = d97_ff;
      rside_in[0].sw   = sww[2:0];
      rside_in[0].sh   = 6'd54 - {1'b0, q67_ff};
      rside_in[0].neg  = neg7_ff;
      rside_in[0].zero = zero7_ff;
      rs_in[0] = s7_ff;
      for (int c = 0; c < 3; c++) begin
         rr_in[0][c] = 65'(u7_ff[c]);
         rq_in[0][c] = '0;
      end

      // divisor 8*S keeps u below it; 33 quotient bits give u*2^30/S
      for (int k = 0; k < RS; k++) begin
         for (int c = 0; c < 3; c++) begin
            rr2 = {rr_ff[k][c], 1'b0};
            rdd = {1'b0, rs_ff[k], 3'b000};
            if (rr2 >= rdd) begin
               rr_in[k+1][c] = 65'(rr2 - rdd);
               xbit = 1'b1;
            end else begin
               rr_in[k+1][c] = rr2[64:0];
               xbit = 1'b0;
            end
            rq_in[k+1][c] = {rq_ff[k][c][31:0], xbit};
         end
         rs_in[k+1]    = rs_ff[k];
         rside_in[k+1] = rside_ff[k];
      end

      for (int c = 0; c < 3; c++) begin
         qv_in[0][c]    = {1'b0, rq_ff[RS][c], 30'b0};
         qrem_in[0][c]  = '0;
         qroot_in[0][c] = '0;
      end
      qside_in[0] = rside_ff[RS];

      for (int k = 0; k < QS; k++) begin
         for (int c = 0; c < 3; c++) begin
            qremx  = {qrem_ff[k][c], qv_ff[k][c][63:62]};
            qtrial = {2'b00, qroot_ff[k][c], 2'b01};
            if (qremx >= qtrial) begin
               qrem_in[k+1][c]  = 34'(qremx - qtrial);
               qroot_in[k+1][c] = {qroot_ff[k][c][30:0], 1'b1};
            end else begin
               qrem_in[k+1][c]  = qremx[33:0];
               qroot_in[k+1][c] = {qroot_ff[k][c][30:0], 1'b0};
            end
            qv_in[k+1][c] = {qv_ff[k][c][61:0], 2'b00};
         end
         qside_in[k+1] = qside_ff[k];
      end

      wr_in[0]  = qside_ff[QS].w0;
      wd_in[0]  = qside_ff[QS].d9;
      wq_in[0]  = '0;
      wsw_in[0] = qside_ff[QS].sw;
      for (int c = 0; c < 3; c++) wtail_in[0].q[c] = qroot_ff[QS][c];
      wtail_in[0].sh   = qside_ff[QS].sh;
      wtail_in[0].neg  = qside_ff[QS].neg;
      wtail_in[0].zero = qside_ff[QS].zero;

      for (int k = 0; k < WS; k++) begin
         wr2 = {wr_ff[k], 1'b0};
         wdd = {1'b0, wd_ff[k]};
         if (wr2 >= wdd) begin
            wr_in[k+1] = 66'(wr2 - wdd);
            xbit = 1'b1;
         end else begin
            wr_in[k+1] = wr2[65:0];
            xbit = 1'b0;
         end
         wq_in[k+1]    = {wq_ff[k][58:0], xbit};
         wd_in[k+1]    = wd_ff[k];
         wsw_in[k+1]   = wsw_ff[k];
         wtail_in[k+1] = wtail_ff[k];
      end

      // h^3 <= floor(sqrt(W*2^64)) is the same test as h^6 <= W*2^64
      wv = 59'(wq_ff[WS] >> wsw_ff[WS]);
      tv_in[0]    = {1'b0, wv, 64'b0};
      trem_in[0]  = '0;
      troot_in[0] = '0;
      ttail_in[0] = wtail_ff[WS];

      for (int k = 0; k < TS; k++) begin
         tremx  = {trem_ff[k], tv_ff[k][123:122]};
         ttrial = {2'b00, troot_ff[k], 2'b01};
         if (tremx >= ttrial) begin
            trem_in[k+1]  = 64'(tremx - ttrial);
            troot_in[k+1] = {troot_ff[k][60:0], 1'b1};
         end else begin
            trem_in[k+1]  = tremx[63:0];
            troot_in[k+1] = {troot_ff[k][60:0], 1'b0};
         end
         tv_in[k+1]    = {tv_ff[k][121:0], 2'b00};
         ttail_in[k+1] = ttail_ff[k];
      end

      ct_in[0]    = troot_ff[TS];
      ch_in[0]    = '0;
      cc_in[0]    = '0;
      c2_in[0]    = '0;
      ctail_in[0] = ttail_ff[TS];

      for (int j = 0; j < dfps_pkg::H_W; j++) begin
         // candidate square
         ccand = ch_ff[2*j] | (21'd1 << (dfps_pkg::H_W - 1 - j));
         cc_in[2*j+1]    = ccand;
         c2_in[2*j+1]    = ccand * ccand;
         ch_in[2*j+1]    = ch_ff[2*j];
         ct_in[2*j+1]    = ct_ff[2*j];
         ctail_in[2*j+1] = ctail_ff[2*j];
         // candidate cube and compare
         c3 = c2_ff[2*j+1] * cc_ff[2*j+1];
         ch_in[2*j+2]    = (c3 <= 63'(ct_ff[2*j+1])) ? cc_ff[2*j+1] : ch_ff[2*j+1];
         cc_in[2*j+2]    = cc_ff[2*j+1];
         c2_in[2*j+2]    = c2_ff[2*j+1];
         ct_in[2*j+2]    = ct_ff[2*j+1];
         ctail_in[2*j+2] = ctail_ff[2*j+1];
      end

      for (int c = 0; c < 3; c++) begin
         prod_in[c] = ctail_ff[CS].q[c] * ch_ff[CS];
      end
      ftail_in = ctail_ff[CS];

      for (int c = 0; c < 3; c++) begin
         shifted = prod_ff[c] >> ftail_ff.sh;
         if (ftail_ff.zero || ftail_ff.neg[c]) begin
            pos_in[c] = '0;
         end else if (|shifted[52:32]) begin
            pos_in[c] = '1;
         end else begin
            pos_in[c] = shifted[31:0];
         end
      end
      if (ftail_ff.zero) begin
         status_in = dfps_pkg::STATUS_ZERO;
      end else if (|ftail_ff.neg) begin
         status_in = dfps_pkg::STATUS_NEG;
      end else begin
         status_in = dfps_pkg::STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[LAT-2:0], start};
      end
   end

   always_ff @(posedge clock) begin
      xr_ff    <= xr_in;
      xq_ff    <= xq_in;
      xd_ff    <= xd_in;
      x1_ff    <= x1_in;
      e1_ff    <= e1_in;
      e2_ff    <= e2_in;
      e3_ff    <= e3_in;
      e4_ff    <= e4_in;
      e5_ff    <= e5_in;
      e6_ff    <= e6_in;
      y2_ff    <= y2_in;
      sq3_ff   <= sq3_in;
      col4_ff  <= col4_in;
      col5_ff  <= col5_in;
      s5_ff    <= s5_in;
      s6_ff    <= s6_in;
      s7_ff    <= s7_in;
      l6_ff    <= l6_in;
      l7_ff    <= l7_in;
      d96_ff   <= d96_in;
      d97_ff   <= d97_in;
      u6_ff    <= u6_in;
      u7_ff    <= u7_in;
      neg6_ff  <= neg6_in;
      neg7_ff  <= neg7_in;
      zero6_ff <= zero6_in;
      zero7_ff <= zero7_in;
      l97_ff   <= l97_in;
      a7_ff    <= a7_in;
      q67_ff   <= q67_in;
      rr_ff    <= rr_in;
      rq_ff    <= rq_in;
      rs_ff    <= rs_in;
      rside_ff <= rside_in;
      qv_ff    <= qv_in;
      qrem_ff  <= qrem_in;
      qroot_ff <= qroot_in;
      qside_ff <= qside_in;
      wr_ff    <= wr_in;
      wd_ff    <= wd_in;
      wq_ff    <= wq_in;
      wsw_ff   <= wsw_in;
      wtail_ff <= wtail_in;
      tv_ff    <= tv_in;
      trem_ff  <= trem_in;
      troot_ff <= troot_in;
      ttail_ff <= ttail_in;
      ct_ff    <= ct_in;
      ch_ff    <= ch_in;
      cc_ff    <= cc_in;
      c2_ff    <= c2_in;
      ctail_ff <= ctail_in;
      prod_ff  <= prod_in;
      ftail_ff <= ftail_in;
      pos_ff   <= pos_in;
      status_ff <= status_in;
   end

   assign rsp_valid  = vld_ff[LAT-1];
   assign rsp_pos_a  = pos_ff[0];
   assign rsp_pos_b  = pos_ff[1];
   assign rsp_pos_c  = pos_ff[2];
   assign rsp_status = status_ff;

endmodule

`default_nettype wire

// File: test/testbench.sv
// Self-checking testbench for the dipole field position solver.
`timescale 1ns / 1ps
`default_nettype none

module testbench;

   localparam logic [2:0] CSR_UNUSED = 3'd7;   // no register behind this index
   localparam int LATENCY    = 332;
   localparam int IDLE_LIMIT = 5000;
   localparam int N_RANDOM   = 1400;

   typedef struct {
      logic [31:0] pos [3];
      logic [1:0]  status;
   } solution_type;

   typedef struct {
      logic [23:0]  m [9];
      bit           typed;
      solution_type sol;
   } matrix_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [23:0] meas [9];
   logic        rsp_valid;
   logic [31:0] rsp_pos_a, rsp_pos_b, rsp_pos_c;
   logic [1:0]  rsp_status;
   logic        csr_write_en = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   // shadow copy of the registers
   logic [8:0]  flip_shadow;
   logic [31:0] tx_shadow [3];
   logic [31:0] rx_shadow [3];

   solution_type solutions_due [$];
   int          error_count = 0;
   int          accept_count = 0;
   int          idle_cycles = 0;

   initial for (int i = 0; i < 9; i++) meas[i] = '0;

   always #5 clock = ~clock;

   dipole_field_position_solver dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_m00(meas[0]), .req_m01(meas[1]), .req_m02(meas[2]),
      .req_m10(meas[3]), .req_m11(meas[4]), .req_m12(meas[5]),
      .req_m20(meas[6]), .req_m21(meas[7]), .req_m22(meas[8]),
      .rsp_valid(rsp_valid), .rsp_pos_a(rsp_pos_a), .rsp_pos_b(rsp_pos_b),
      .rsp_pos_c(rsp_pos_c), .rsp_status(rsp_status),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   function automatic int bit_len(logic [127:0] v);
      int n;
      n = 0;
      for (int i = 0; i < 128; i++) if (v[i]) n = i + 1;
      return n;
   endfunction

   // Fixed-point position solve from the current register copy.
   function automatic solution_type solve_position(logic [23:0] m [9]);
      solution_type sol;
      logic [127:0] x [9];
      logic [63:0]  y, col [3], s, wq, h, six, u, r, q, prod, pos, c3;
      logic [127:0] num, c6, qq;
      logic [63:0]  tg, rg, mag;
      int           maxbl, e, big_e, len, n, p, sh;
      maxbl = 0;
      for (int i = 0; i < 9; i++) begin
         mag = m[i][23] ? 64'h100_0000 - m[i] : m[i];
         tg = (tx_shadow[i / 3] == 0) ? 64'd1 : tx_shadow[i / 3];
         rg = (rx_shadow[i % 3] == 0) ? 64'd1 : rx_shadow[i % 3];
         num = {mag, 64'd0};
         x[i] = num / (tg * rg);
         if (bit_len(x[i]) > maxbl) maxbl = bit_len(x[i]);
      end
      e = (maxbl > 29) ? maxbl - 29 : 0;
      for (int k = 0; k < 3; k++) col[k] = 0;
      for (int i = 0; i < 9; i++) begin
         y = 64'((x[i] >> e) & 128'h1FFF_FFFF);
         col[i % 3] += y * y;
      end
      s = col[0] + col[1] + col[2];
      sol.status = dfps_pkg::STATUS_OK;
      for (int k = 0; k < 3; k++) sol.pos[k] = '0;
      if (s == 0) begin
         sol.status = dfps_pkg::STATUS_ZERO;
         return sol;
      end
      big_e = 65 - 2 * e;
      len = bit_len({64'd0, s});
      n = (big_e - len + 120) / 6 - 20;
      p = big_e - 6 * n + 56;
      num = 128'd1 << p;
      qq = num / s;
      wq = qq[63:0] / 64'd9;
      // sixth root, one bit at a time
      h = 0;
      for (int b = 20; b >= 0; b--) begin
         c3 = (h | (64'd1 << b));
         c3 = c3 * c3 * c3;
         c6 = {64'd0, c3} * {64'd0, c3};
         if (c6 <= {wq, 64'd0}) h = h | (64'd1 << b);
      end
      for (int k = 0; k < 3; k++) begin
         six = 6 * col[k];
         if (six < s) begin
            sol.status = dfps_pkg::STATUS_NEG;
            continue;
         end
         u = six - s;
         num = {64'd0, u} << 30;
         qq = num / s;
         r = qq[63:0] << 30;
         q = 0;
         for (int b = 31; b >= 0; b--) begin
            c6 = {64'd0, q | (64'd1 << b)};
            if (c6 * c6 <= {64'd0, r}) q = q | (64'd1 << b);
         end
         prod = q * h;
         sh = 34 - n;
         if (sh >= 64) pos = 0;
         else if (sh < 0) pos = (prod != 0) ? 64'hFFFF_FFFF : 64'd0;
         else pos = prod >> sh;
         sol.pos[k] = (pos > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : pos[31:0];
      end
      return sol;
   endfunction

   task automatic write_reg(logic [2:0] index, logic [31:0] value);
      @(negedge clock);
      csr_write_en = 1'b1;
      csr_index = index;
      csr_wdata = value;
      case (index)
         dfps_pkg::CSR_FLIP_MASK: flip_shadow = value[8:0];
         dfps_pkg::CSR_TX_GAIN0:  tx_shadow[0] = value;
         dfps_pkg::CSR_TX_GAIN1:  tx_shadow[1] = value;
         dfps_pkg::CSR_TX_GAIN2:  tx_shadow[2] = value;
         dfps_pkg::CSR_RX_GAIN0:  rx_shadow[0] = value;
         dfps_pkg::CSR_RX_GAIN1:  rx_shadow[1] = value;
         dfps_pkg::CSR_RX_GAIN2:  rx_shadow[2] = value;
         default: ;
      endcase
      @(negedge clock);
      csr_write_en = 1'b0;
   endtask

   task automatic set_gains(logic [8:0] mask, logic [31:0] tx [3], logic [31:0] rx [3]);
      write_reg(dfps_pkg::CSR_FLIP_MASK, {23'd0, mask});
      write_reg(dfps_pkg::CSR_TX_GAIN0, tx[0]);
      write_reg(dfps_pkg::CSR_TX_GAIN1, tx[1]);
      write_reg(dfps_pkg::CSR_TX_GAIN2, tx[2]);
      write_reg(dfps_pkg::CSR_RX_GAIN0, rx[0]);
      write_reg(dfps_pkg::CSR_RX_GAIN1, rx[1]);
      write_reg(dfps_pkg::CSR_RX_GAIN2, rx[2]);
   endtask

   // Called at a falling edge; leaves start high until the transaction is taken.
   task automatic send_matrix(logic [23:0] m [9], bit typed, solution_type sol);
      int gap, seen;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      for (int i = 0; i < 9; i++) meas[i] = m[i];
      start = 1'b1;
      seen = accept_count;
      do @(negedge clock); while (accept_count == seen);
      if (typed) solutions_due.push_back(sol);
      else solutions_due.push_back(solve_position(m));
   endtask

   task automatic drain;
      start = 1'b0;
      while (solutions_due.size() != 0) @(negedge clock);
      repeat (LATENCY + 8) @(negedge clock);
   endtask

   function automatic logic [23:0] rand_elem(int style);
      case (style)
         0: return 24'($urandom);
         1: return 24'($urandom >> $urandom_range(8, 31));
         2: return 24'd0;
         3: return $urandom_range(0, 1) ? 24'h7F_FFFF : 24'h80_0000;
         default: return 24'(($urandom >> $urandom_range(8, 31)) ^
                             ($urandom_range(0, 1) ? 32'hFF_FFFF : 32'd0));
      endcase
   endfunction

   function automatic logic [31:0] rand_gain();
      case ($urandom_range(0, 4))
         0: return $urandom;
         1: return $urandom >> $urandom_range(0, 31);
         2: return 32'd65536 + ($urandom_range(0, 65535) - 32768);
         3: return 32'd1 << $urandom_range(0, 31);
         default: return 32'd65536;
      endcase
   endfunction

   // accepted-transaction count and results checking
   always @(posedge clock) begin
      solution_type want;
      if (!reset) begin
         if (start && !busy) accept_count <= accept_count + 1;
         if (start && !busy || rsp_valid) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (rsp_valid) begin
            if (solutions_due.size() == 0) begin
               $error("unexpected result transaction");
               error_count++;
            end else begin
               want = solutions_due.pop_front();
               if (rsp_pos_a !== want.pos[0]) begin
                  $error("pos_a expected %0h got %0h", want.pos[0], rsp_pos_a);
                  error_count++;
               end
               if (rsp_pos_b !== want.pos[1]) begin
                  $error("pos_b expected %0h got %0h", want.pos[1], rsp_pos_b);
                  error_count++;
               end
               if (rsp_pos_c !== want.pos[2]) begin
                  $error("pos_c expected %0h got %0h", want.pos[2], rsp_pos_c);
                  error_count++;
               end
               if (rsp_status !== want.status) begin
                  $error("status expected %0d got %0d", want.status, rsp_status);
                  error_count++;
               end
            end
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   initial begin
      matrix_row_type rows [$];
      matrix_row_type row;
      solution_type   zero_sol, none;
      logic [23:0] m [9];
      logic [31:0] tx [3], rx [3];
      int          style, dominant;

      flip_shadow = '0;
      for (int i = 0; i < 3; i++) begin
         tx_shadow[i] = dfps_pkg::GAIN_RESET;
         rx_shadow[i] = dfps_pkg::GAIN_RESET;
      end
      zero_sol.status = dfps_pkg::STATUS_ZERO;
      for (int k = 0; k < 3; k++) zero_sol.pos[k] = '0;
      none = zero_sol;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table: zero energy typed, everything else from the solver
      row.typed = 1'b0;
      row.sol = none;
      for (int r = 0; r < 14; r++) begin
         for (int i = 0; i < 9; i++) row.m[i] = 24'd0;
         row.typed = 1'b0;
         case (r)
            0: begin row.typed = 1'b1; row.sol = zero_sol; end
            1: for (int i = 0; i < 9; i++) row.m[i] = 24'h7F_FFFF;
            2: for (int i = 0; i < 9; i++) row.m[i] = 24'h80_0000;
            3: for (int i = 0; i < 9; i++) row.m[i] = i[0] ? 24'h80_0000 : 24'h7F_FFFF;
            4: row.m[0] = 24'd1;
            5: begin row.m[0] = 24'd1; row.m[1] = 24'd1; row.m[2] = 24'd2; end  // zero radicand
            6: row.m[8] = 24'h7F_FFFF;
            7: begin row.m[0] = 24'd1000; row.m[4] = 24'd1000; row.m[8] = 24'd1000; end
            8: for (int i = 0; i < 9; i++) row.m[i] = 24'hFF_FFFF;
            9: for (int i = 0; i < 9; i++) row.m[i] = 24'd1;
            10: begin row.m[1] = 24'h12_3456; row.m[4] = 24'hED_CBA9; row.m[7] = 24'd77; end
            11: for (int i = 0; i < 9; i++) row.m[i] = (i % 3 == 2) ? 24'h40_0000 : 24'd3;
            12: for (int i = 0; i < 9; i++) row.m[i] = 24'h55_5555 ^ 24'(i * 24'h11_1111);
            13: for (int i = 0; i < 9; i++) row.m[i] = 24'hAA_AAAA;
            default: ;
         endcase
         rows.push_back(row);
      end
      foreach (rows[j]) send_matrix(rows[j].m, rows[j].typed, rows[j].sol);
      drain();

      // register settings: extremes, zero gain, unused index, reset gains, then random ones
      for (int phase = 0; phase < 7; phase++) begin
         case (phase)
            0: begin
               for (int i = 0; i < 3; i++) begin tx[i] = 32'd1; rx[i] = 32'd1; end
               set_gains(9'h1FF, tx, rx);
            end
            1: begin
               for (int i = 0; i < 3; i++) begin tx[i] = 32'hFFFF_FFFF; rx[i] = 32'hFFFF_FFFF; end
               set_gains(9'h0AA, tx, rx);
            end
            2: begin
               for (int i = 0; i < 3; i++) begin tx[i] = 32'd0; rx[i] = dfps_pkg::GAIN_RESET; end
               rx[1] = 32'd0;
               set_gains(9'h155, tx, rx);
               write_reg(CSR_UNUSED, 32'hDEAD_BEEF);
            end
            3: begin
               for (int i = 0; i < 3; i++) begin
                  tx[i] = dfps_pkg::GAIN_RESET;
                  rx[i] = dfps_pkg::GAIN_RESET;
               end
               set_gains(9'h000, tx, rx);
            end
            default: begin
               for (int i = 0; i < 3; i++) begin tx[i] = rand_gain(); rx[i] = rand_gain(); end
               set_gains(9'($urandom_range(0, 511)), tx, rx);
            end
         endcase
         // the zero matrix stays zero under any setting
         for (int i = 0; i < 9; i++) m[i] = 24'd0;
         send_matrix(m, 1'b1, zero_sol);
         for (int it = 0; it < N_RANDOM / 7; it++) begin
            style = $urandom_range(0, 4);
            dominant = $urandom_range(0, 5);
            for (int i = 0; i < 9; i++) begin
               m[i] = rand_elem(($urandom_range(0, 3) == 0) ? $urandom_range(0, 4) : style);
               // sometimes starve two columns to reach the clamped radicand case
               if (dominant < 3 && i % 3 != dominant && $urandom_range(0, 1))
                  m[i] = m[i] >> $urandom_range(8, 24);
            end
            send_matrix(m, 1'b0, none);
            // stretch without idling
            if (it % 97 == 50)
               for (int b = 0; b < 20; b++) begin
                  for (int i = 0; i < 9; i++) m[i] = 24'($urandom);
                  for (int i = 0; i < 9; i++) meas[i] = m[i];
                  start = 1'b1;
                  @(negedge clock);
                  solutions_due.push_back(solve_position(m));
               end
         end
         drain();
      end

      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

`default_nettype wire

// File: files.f
rtl/core/dfps_pkg.sv
rtl/core/dipole_field_position_solver.sv
test/testbench.sv
